// ===== src/ttc_pkg.sv =====
`default_nettype none
// ============================================================================
// ttc_pkg: shared definitions for the tiled text console renderer
// Field widths, reset values, command and state codes, and cursor helpers.
// ============================================================================
package ttc_pkg;

    localparam int FONT_BYTES_DEF  = 4096;
    localparam int ADDR_BITS_DEF   = 22;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int FONT_IDX_W = 12;
    localparam int CHAR_W     = 8;
    localparam int CURSOR_W   = 8;
    localparam int GLYPH_ROWS = 16;
    localparam int ROW_W      = 4;
    localparam int TW_W       = 13;
    localparam int COLOR_W    = 32;
    localparam int BAND_W     = CURSOR_W - 1;
    localparam int PROD_W     = BAND_W + TW_W;
    localparam int TILE_SHIFT = 5;
    localparam int BASE_W     = PROD_W + TILE_SHIFT;
    localparam int SUM_W      = BASE_W + 1;
    localparam int LOW_W      = 16;
    localparam int NUM_PIX    = 8;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [CURSOR_W-1:0] ROW_STEP_BACK = 8'd2;
    localparam logic [CHAR_W-1:0]   CHAR_CR       = 8'd13;
    localparam logic [CHAR_W-1:0]   CHAR_LF       = 8'd10;

    localparam logic [TW_W-1:0]     TILED_WIDTH_RST  = 13'd1280;
    localparam logic [CURSOR_W-1:0] TEXT_COLUMNS_RST = 8'd160;
    localparam logic [CURSOR_W-1:0] TEXT_ROWS_RST    = 8'd45;
    localparam logic [COLOR_W-1:0]  COLOR_BG_RST     = 32'h0000_0000;
    localparam logic [COLOR_W-1:0]  COLOR_FG_RST     = 32'hFFA0_A000;

    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    typedef enum logic [2:0] {
        REG_TILED_WIDTH,
        REG_TEXT_COLUMNS,
        REG_TEXT_ROWS,
        REG_COLOR_BG,
        REG_COLOR_FG
    } ttc_reg_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_CR,
        OP_NL,
        OP_GLYPH
    } ttc_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ROWS,
        ST_SCROLL
    } ttc_state_t;

    typedef struct packed {
        ttc_op_t                 op;
        logic [FONT_IDX_W-1:0]   index;
        logic [CHAR_W-1:0]       data;
    } ttc_cmd_t;

    typedef struct packed {
        logic [TW_W-1:0]     tiled_width;
        logic [CURSOR_W-1:0] text_columns;
        logic [CURSOR_W-1:0] text_rows;
        logic [COLOR_W-1:0]  color_bg;
        logic [COLOR_W-1:0]  color_fg;
    } ttc_cfg_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] col;
        logic [CURSOR_W-1:0] row;
        logic                scroll;
    } ttc_cursor_t;

    function automatic ttc_cursor_t next_line(input logic [CURSOR_W-1:0] row,
                                              input logic [CURSOR_W-1:0] rows);
        ttc_cursor_t         cur;
        logic [CURSOR_W-1:0] row_inc;
        row_inc    = row + CURSOR_W'(1);
        cur.col    = '0;
        cur.row    = row_inc;
        cur.scroll = 1'b0;
        if (row_inc >= rows)
        begin
            cur.row    = (row_inc >= ROW_STEP_BACK) ? row_inc - ROW_STEP_BACK : '0;
            cur.scroll = 1'b1;
        end
        return cur;
    endfunction

endpackage
`default_nettype wire

// ===== src/ttc_in_if.sv =====
`default_nettype none
// ============================================================================
// ttc_in_if: input channel of the tiled text console renderer
// Carries one font load or one character per transaction.
// ============================================================================
interface ttc_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [11:0] font_index;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;

    modport source (output valid, output mode, output font_index, output font_byte,
                    output char_code, input ready);
    modport sink   (input valid, input mode, input font_index, input font_byte,
                    input char_code, output ready);
endinterface
`default_nettype wire

// ===== src/ttc_out_if.sv =====
`default_nettype none
// ============================================================================
// ttc_out_if: result channel of the tiled text console renderer
// Carries one pixel row write or one scroll request per transaction.
// ============================================================================
interface ttc_out_if #(
    parameter int ADDR_BITS = 22
);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] addr_first;
    logic [ADDR_BITS-1:0] addr_second;
    logic [31:0]          pixel0;
    logic [31:0]          pixel1;
    logic [31:0]          pixel2;
    logic [31:0]          pixel3;
    logic [31:0]          pixel4;
    logic [31:0]          pixel5;
    logic [31:0]          pixel6;
    logic [31:0]          pixel7;
    logic                 last;

    modport source (output valid, output kind, output addr_first, output addr_second,
                    output pixel0, output pixel1, output pixel2, output pixel3,
                    output pixel4, output pixel5, output pixel6, output pixel7,
                    output last, input ready);
    modport sink   (input valid, input kind, input addr_first, input addr_second,
                    input pixel0, input pixel1, input pixel2, input pixel3,
                    input pixel4, input pixel5, input pixel6, input pixel7,
                    input last, output ready);
endinterface
`default_nettype wire

// ===== src/tiled_text_console_renderer.sv =====
`default_nettype none
// ============================================================================
// tiled_text_console_renderer: text console for a 32x32 tiled framebuffer
// Front stage, command queue and back stage with font store, cursor and
// configuration registers behind an APB port.
// ============================================================================
// Flow: a printable character occupies the back stage to take the command,
//   to latch the cursor and tile band base, then for one font read per cycle
//   while the result channel does not stall, each row leaving through the result
//   register after its registered font read; a scroll request adds a scroll state.
// Font loads and returns are handled in the idle state; a newline also needs the scroll state when it scrolls.
// Reset: cursor at column 0 row 0, registers at defaults, queue empty; font store not cleared.
module tiled_text_console_renderer #(
    parameter int FONT_BYTES  = ttc_pkg::FONT_BYTES_DEF,
    parameter int ADDR_BITS   = ttc_pkg::ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH = ttc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ttc_in_if.sink                     in_ch,
    ttc_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ttc_pkg::APB_AW-1:0] paddr,
    input  logic [ttc_pkg::APB_DW-1:0] pwdata,
    output logic [ttc_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import ttc_pkg::*;

    ttc_cfg_t   cfg_reg;
    ttc_cfg_t   cfg_next;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic     push_valid;
    logic     push_ready;
    ttc_cmd_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    ttc_cmd_t pop_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_TILED_WIDTH:  cfg_next.tiled_width  = pwdata[TW_W-1:0];
                REG_TEXT_COLUMNS: cfg_next.text_columns = pwdata[CURSOR_W-1:0];
                REG_TEXT_ROWS:    cfg_next.text_rows    = pwdata[CURSOR_W-1:0];
                REG_COLOR_BG:     cfg_next.color_bg     = pwdata;
                REG_COLOR_FG:     cfg_next.color_fg     = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TILED_WIDTH:  prdata = APB_DW'(cfg_reg.tiled_width);
            REG_TEXT_COLUMNS: prdata = APB_DW'(cfg_reg.text_columns);
            REG_TEXT_ROWS:    prdata = APB_DW'(cfg_reg.text_rows);
            REG_COLOR_BG:     prdata = cfg_reg.color_bg;
            REG_COLOR_FG:     prdata = cfg_reg.color_fg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tiled_width  <= TILED_WIDTH_RST;
            cfg_reg.text_columns <= TEXT_COLUMNS_RST;
            cfg_reg.text_rows    <= TEXT_ROWS_RST;
            cfg_reg.color_bg     <= COLOR_BG_RST;
            cfg_reg.color_fg     <= COLOR_FG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ttc_front #(
        .FONT_BYTES (FONT_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ttc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ttc_back #(
        .FONT_BYTES (FONT_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

// ===== src/ttc_ram.sv =====
`default_nettype none
// ============================================================================
// ttc_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ============================================================================
module ttc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/ttc_front.sv =====
`default_nettype none
// ============================================================================
// ttc_front: input stage of the tiled text console renderer
// Accepts input transactions, classifies them into commands and drops font
// loads that fall outside the font store.
// ============================================================================
module ttc_front #(
    parameter int FONT_BYTES = ttc_pkg::FONT_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ttc_in_if.sink            in_ch,
    output logic              push_valid,
    input  logic              push_ready,
    output ttc_pkg::ttc_cmd_t push_data
);
    import ttc_pkg::*;

    localparam logic [FONT_IDX_W:0] FONT_LIMIT = (FONT_IDX_W + 1)'(FONT_BYTES);

    logic     stg_valid_reg;
    logic     stg_valid_next;
    ttc_cmd_t stg_cmd_reg;
    ttc_cmd_t cmd;
    logic     keep;
    logic     accept;

    always_comb
    begin
        cmd.index = in_ch.font_index;
        cmd.data  = in_ch.mode ? in_ch.char_code : in_ch.font_byte;
        cmd.op    = OP_GLYPH;
        keep      = 1'b1;
        if (!in_ch.mode)
        begin
            cmd.op = OP_LOAD;
            keep   = ({1'b0, in_ch.font_index} < FONT_LIMIT);
        end
        else if (in_ch.char_code == CHAR_CR)
        begin
            cmd.op = OP_CR;
        end
        else if (in_ch.char_code == CHAR_LF)
        begin
            cmd.op = OP_NL;
        end
    end

    assign in_ch.ready = !stg_valid_reg || push_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (accept)
        begin
            stg_valid_next = keep;
        end
        else if (push_ready)
        begin
            stg_valid_next = 1'b0;
        end
        else
        begin
            stg_valid_next = stg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_cmd_reg <= cmd;
        end
    end

    assign push_valid = stg_valid_reg;
    assign push_data  = stg_cmd_reg;

endmodule
`default_nettype wire

// ===== src/ttc_fifo.sv =====
`default_nettype none
// ============================================================================
// ttc_fifo: command queue between the front and back of the renderer
// A small register queue so that each side can stall on its own.
// ============================================================================
module ttc_fifo #(
    parameter int DEPTH = ttc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ttc_pkg::ttc_cmd_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ttc_pkg::ttc_cmd_t pop_data
);
    import ttc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttc_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/ttc_back.sv =====
`default_nettype none
// ============================================================================
// ttc_back: execution stage of the tiled text console renderer
// Owns the font store and the cursor, renders glyph rows from font reads and
// drives the registered result channel.
// ============================================================================
module ttc_back #(
    parameter int FONT_BYTES = ttc_pkg::FONT_BYTES_DEF,
    parameter int ADDR_BITS  = ttc_pkg::ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ttc_pkg::ttc_cfg_t cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  ttc_pkg::ttc_cmd_t pop_data,
    ttc_out_if.source         out_ch
);
    import ttc_pkg::*;

    localparam int FIDX_W = $clog2(FONT_BYTES);
    localparam logic [FONT_IDX_W:0] FONT_LIMIT = (FONT_IDX_W + 1)'(FONT_BYTES);
    localparam logic [ROW_W-1:0]    LAST_ROW   = ROW_W'(GLYPH_ROWS - 1);

    ttc_state_t state_reg;
    ttc_state_t state_next;

    logic [CURSOR_W-1:0] col_reg, col_next;
    logic [CURSOR_W-1:0] row_reg, row_next;
    logic [CHAR_W-1:0]   g_ch_reg, g_ch_next;
    logic [CURSOR_W-1:0] g_col_reg, g_col_next;
    logic [CURSOR_W-1:0] g_row_reg, g_row_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic                scroll_due_reg, scroll_due_next;
    logic [ROW_W-1:0]    rd_row_reg, rd_row_next;
    logic                rd_done_reg, rd_done_next;
    logic                pend_reg, pend_next;
    logic [ROW_W-1:0]    em_row_reg, em_row_next;
    logic                oob_reg, oob_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, kind_next;
    logic [ADDR_BITS-1:0] addr_first_reg, addr_first_next;
    logic [ADDR_BITS-1:0] addr_second_reg, addr_second_next;
    logic [COLOR_W-1:0]   pix_reg [NUM_PIX];
    logic [COLOR_W-1:0]   pix_next [NUM_PIX];
    logic                 last_reg, last_next;

    logic              ram_we;
    logic              ram_re;
    logic [FIDX_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;
    logic [FONT_IDX_W-1:0] rd_full;

    ttc_cursor_t       nl_cur;
    ttc_cursor_t       gl_cur;
    logic [CURSOR_W-1:0] col_inc;
    logic [PROD_W-1:0] prod;
    logic              out_free;
    logic              emit_fire;
    logic              issue;
    logic              load_row;
    logic              load_scroll;
    logic [CHAR_W-1:0] bits;
    logic [LOW_W-1:0]  low_first;
    logic [LOW_W-1:0]  low_second;
    logic [SUM_W-1:0]  flip;
    logic [SUM_W-1:0]  sum_first;
    logic [SUM_W-1:0]  sum_second;

    ttc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FONT_BYTES)
    ) u_font (
        .clk   (clk),
        .we    (ram_we),
        .waddr (FIDX_W'(pop_data.index)),
        .wdata (pop_data.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nl_cur  = next_line(row_reg, cfg.text_rows);
    assign col_inc = col_reg + CURSOR_W'(1);
    assign prod    = PROD_W'(row_reg[CURSOR_W-1:1]) * PROD_W'(cfg.tiled_width);

    always_comb
    begin
        if (col_inc == '0 || col_inc >= cfg.text_columns)
        begin
            gl_cur = nl_cur;
        end
        else
        begin
            gl_cur.col    = col_inc;
            gl_cur.row    = row_reg;
            gl_cur.scroll = 1'b0;
        end
    end

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign emit_fire = (state_reg == ST_ROWS) && pend_reg && out_free;
    assign issue     = (state_reg == ST_ROWS) && !rd_done_reg && (!pend_reg || emit_fire);
    assign rd_full   = {g_ch_reg, rd_row_reg};
    assign ram_raddr = FIDX_W'(rd_full);
    assign ram_re    = issue;
    assign pop_ready = (state_reg == ST_IDLE);
    assign ram_we    = (state_reg == ST_IDLE) && pop_valid && (pop_data.op == OP_LOAD);
    assign load_row    = emit_fire;
    assign load_scroll = (state_reg == ST_SCROLL) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_data.op == OP_GLYPH)
                    begin
                        state_next = ST_START;
                    end
                    else if (pop_data.op == OP_NL && nl_cur.scroll)
                    begin
                        state_next = ST_SCROLL;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_ROWS;
            end
            ST_ROWS:
            begin
                if (emit_fire && em_row_reg == LAST_ROW)
                begin
                    state_next = scroll_due_reg ? ST_SCROLL : ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        g_ch_next       = g_ch_reg;
        g_col_next      = g_col_reg;
        g_row_next      = g_row_reg;
        base_next       = base_reg;
        scroll_due_next = scroll_due_reg;
        rd_row_next     = rd_row_reg;
        rd_done_next    = rd_done_reg;
        pend_next       = pend_reg;
        em_row_next     = em_row_reg;
        oob_next        = oob_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    case (pop_data.op)
                        OP_CR:
                        begin
                            col_next = '0;
                        end
                        OP_NL:
                        begin
                            col_next = nl_cur.col;
                            row_next = nl_cur.row;
                        end
                        OP_GLYPH:
                        begin
                            g_ch_next = pop_data.data;
                        end
                        default:
                        begin
                            g_ch_next = g_ch_reg;
                        end
                    endcase
                end
            end
            ST_START:
            begin
                g_col_next      = col_reg;
                g_row_next      = row_reg;
                base_next       = {prod, {TILE_SHIFT{1'b0}}};
                scroll_due_next = gl_cur.scroll;
                col_next        = gl_cur.col;
                row_next        = gl_cur.row;
                rd_row_next     = '0;
                rd_done_next    = 1'b0;
                pend_next       = 1'b0;
            end
            ST_ROWS:
            begin
                if (issue)
                begin
                    pend_next    = 1'b1;
                    em_row_next  = rd_row_reg;
                    oob_next     = ({1'b0, rd_full} >= FONT_LIMIT);
                    rd_row_next  = rd_row_reg + ROW_W'(1);
                    rd_done_next = (rd_row_reg == LAST_ROW);
                end
                else if (emit_fire)
                begin
                    pend_next = 1'b0;
                end
            end
            ST_SCROLL:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    assign bits       = oob_reg ? '0 : ram_rdata;
    assign low_first  = {g_col_reg[CURSOR_W-1:2], g_row_reg[0], em_row_reg[3:1],
                         g_col_reg[1:0], 1'b0, em_row_reg[0], 2'b00};
    assign low_second = {g_col_reg[CURSOR_W-1:2], g_row_reg[0], em_row_reg[3:1],
                         g_col_reg[1:0], 1'b1, em_row_reg[0], 2'b00};
    assign flip       = SUM_W'({em_row_reg[3], 5'b00000});
    assign sum_first  = (SUM_W'(base_reg) + SUM_W'(low_first)) ^ flip;
    assign sum_second = (SUM_W'(base_reg) + SUM_W'(low_second)) ^ flip;

    always_comb
    begin
        kind_next        = kind_reg;
        addr_first_next  = addr_first_reg;
        addr_second_next = addr_second_reg;
        last_next        = last_reg;
        for (int i = 0; i < NUM_PIX; i++)
        begin
            pix_next[i] = pix_reg[i];
        end
        if (load_row)
        begin
            kind_next        = KIND_ROW;
            addr_first_next  = ADDR_BITS'(sum_first);
            addr_second_next = ADDR_BITS'(sum_second);
            last_next        = (em_row_reg == LAST_ROW) && !scroll_due_reg;
            for (int i = 0; i < NUM_PIX; i++)
            begin
                pix_next[i] = bits[NUM_PIX-1-i] ? cfg.color_fg : cfg.color_bg;
            end
        end
        else if (load_scroll)
        begin
            kind_next        = KIND_SCROLL;
            addr_first_next  = '0;
            addr_second_next = '0;
            last_next        = 1'b1;
            for (int i = 0; i < NUM_PIX; i++)
            begin
                pix_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        if (load_row || load_scroll)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= 1'b0;
            rd_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            rd_done_reg   <= rd_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_ch_reg        <= g_ch_next;
        g_col_reg       <= g_col_next;
        g_row_reg       <= g_row_next;
        base_reg        <= base_next;
        scroll_due_reg  <= scroll_due_next;
        rd_row_reg      <= rd_row_next;
        em_row_reg      <= em_row_next;
        oob_reg         <= oob_next;
        kind_reg        <= kind_next;
        addr_first_reg  <= addr_first_next;
        addr_second_reg <= addr_second_next;
        last_reg        <= last_next;
        for (int i = 0; i < NUM_PIX; i++)
        begin
            pix_reg[i] <= pix_next[i];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = kind_reg;
    assign out_ch.addr_first  = addr_first_reg;
    assign out_ch.addr_second = addr_second_reg;
    assign out_ch.pixel0      = pix_reg[0];
    assign out_ch.pixel1      = pix_reg[1];
    assign out_ch.pixel2      = pix_reg[2];
    assign out_ch.pixel3      = pix_reg[3];
    assign out_ch.pixel4      = pix_reg[4];
    assign out_ch.pixel5      = pix_reg[5];
    assign out_ch.pixel6      = pix_reg[6];
    assign out_ch.pixel7      = pix_reg[7];
    assign out_ch.last        = last_reg;

endmodule
`default_nettype wire

// ===== src/ttc_chk.sv =====
`default_nettype none
// ============================================================================
// ttc_chk: port-level checker for the tiled text console renderer
// Watches the result channel and is bound to the top level.
// ============================================================================
module ttc_chk #(
    parameter int ADDR_BITS = ttc_pkg::ADDR_BITS_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 kind,
    input logic [ADDR_BITS-1:0] addr_first,
    input logic [ADDR_BITS-1:0] addr_second,
    input logic [31:0]          pixel0,
    input logic [31:0]          pixel1,
    input logic [31:0]          pixel2,
    input logic [31:0]          pixel3,
    input logic [31:0]          pixel4,
    input logic [31:0]          pixel5,
    input logic [31:0]          pixel6,
    input logic [31:0]          pixel7,
    input logic                 last
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kind) && $stable(addr_first)
            && $stable(addr_second) && $stable(pixel0) && $stable(pixel7) && $stable(last))
        else $error("result payload changed while stalled");

    a_scroll_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> last && addr_first == '0 && addr_second == '0
            && (pixel0 | pixel1 | pixel2 | pixel3 | pixel4 | pixel5 | pixel6 | pixel7) == '0)
        else $error("scroll request is not a bare final transaction");

    a_addr_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> !addr_first[3]
            && addr_second == (addr_first | ADDR_BITS'(8)))
        else $error("second pixel run is not next to the first");

endmodule

bind tiled_text_console_renderer ttc_chk #(
    .ADDR_BITS (ADDR_BITS)
) u_ttc_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .kind        (out_ch.kind),
    .addr_first  (out_ch.addr_first),
    .addr_second (out_ch.addr_second),
    .pixel0      (out_ch.pixel0),
    .pixel1      (out_ch.pixel1),
    .pixel2      (out_ch.pixel2),
    .pixel3      (out_ch.pixel3),
    .pixel4      (out_ch.pixel4),
    .pixel5      (out_ch.pixel5),
    .pixel6      (out_ch.pixel6),
    .pixel7      (out_ch.pixel7),
    .last        (out_ch.last)
);
`default_nettype wire
